FILE: hdl/poi_pkg.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package poi_pkg;

   localparam int CordicWidth = 34;
   localparam logic [23:0] DtMax = 24'hFFFFFF;
   localparam logic [21:0] TurnConst = 22'd2670178;
   localparam logic signed [CordicWidth-1:0] CordicXInit = 34'sd652032874;
   localparam logic [23:0] QuarterTurn = 24'h400000;

   typedef struct packed {
      logic valid;
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
   } cordic_bus_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'h20000000;
         5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B;
         5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43;
         5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E;
         5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53;
         5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/poi_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One registered micro-rotation with a fixed shift, passed on every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module poi_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire poi_pkg::cordic_bus_type bus_in,
   output poi_pkg::cordic_bus_type bus_ff
);
   import poi_pkg::*;

   logic signed [CordicWidth-1:0] dx;
   logic signed [CordicWidth-1:0] dy;
   logic signed [CordicWidth-1:0] t;
   cordic_bus_type bus_in_next;

   always_comb begin
      dx = bus_in.y >>> IDX;
      dy = bus_in.x >>> IDX;
      t = $signed({2'b00, atan_entry(5'(IDX))});
      bus_in_next.valid = bus_in.valid;
      if (!bus_in.z[CordicWidth-1]) begin
         bus_in_next.x = bus_in.x - dx;
         bus_in_next.y = bus_in.y + dy;
         bus_in_next.z = bus_in.z - t;
      end else begin
         bus_in_next.x = bus_in.x + dx;
         bus_in_next.y = bus_in.y - dy;
         bus_in_next.z = bus_in.z + t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff.valid <= bus_in_next.valid;
      end
      bus_ff.x <= bus_in_next.x;
      bus_ff.y <= bus_in_next.y;
      bus_ff.z <= bus_in_next.z;
   end

endmodule

`default_nettype wire

FILE: hdl/planar_odometry_integrator.sv
// One item is in flight at a time, carried through a chain of CORDIC_STEPS rotation cells
// and a short multiply sequencer.
// Reset: synchronous, clears position, heading, previous stamp and method to zero.
// A finished result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose update with Euler or midpoint integration.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_odometry_integrator #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // stamp[39:0], velocity_x[55:40], velocity_y[71:56], yaw_rate[87:72]
   input  wire logic [87:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // pose_x[31:0], pose_y[63:32], heading[87:64]
   output logic [87:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic csr_wdata
);
   import poi_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DT, ST_P, ST_KMUL, ST_TURN, ST_ROT, ST_CORDIC,
      ST_MUL1, ST_MUL2, ST_RX, ST_PX, ST_ACC, ST_OUT
   } state_type;

   state_type state_ff;
   logic method_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic [23:0] angle_ff;
   logic [39:0] last_stamp_ff;
   logic rsp_valid_ff;
   logic [87:0] rsp_data_ff;

   logic [39:0] stamp_ff;
   logic signed [15:0] vx_ff, vy_ff, w_ff;
   logic [23:0] dt_ff;
   logic signed [40:0] p_ff;
   logic [45:0] klo_ff;
   logic signed [39:0] khi_ff;
   logic [23:0] step_ff, half_ff;
   logic folded_ff;
   logic signed [CordicWidth-1:0] c_ff, s_ff;
   logic signed [49:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [30:0] rx_ff, ry_ff;
   logic signed [55:0] qx_ff, qy_ff;

   cordic_bus_type chain [0:CORDIC_STEPS];

   logic [40:0] dt_diff;
   logic [23:0] dt_in;
   logic signed [63:0] full_prod;
   logic [63:0] step_sum, half_sum;
   logic [23:0] rot, fold_angle;
   logic signed [23:0] z_start;
   logic signed [50:0] sum_x, sum_y;
   logic signed [56:0] rq_x, rq_y;
   logic signed [33:0] acc_x, acc_y;
   logic signed [31:0] pos_x_in, pos_y_in;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh07FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -34'sh080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   always_comb begin
      dt_diff = {1'b0, stamp_ff} - {1'b0, last_stamp_ff};
      if (dt_diff[40]) begin
         dt_in = '0;
      end else if (dt_diff[39:24] != '0) begin
         dt_in = DtMax;
      end else begin
         dt_in = dt_diff[23:0];
      end
      full_prod = (64'(khi_ff) <<< 24) + $signed({18'd0, klo_ff});
      step_sum = full_prod + 64'sh80000000;
      half_sum = full_prod + 64'sh100000000;
      rot = method_ff ? angle_ff + half_ff : angle_ff;
      fold_angle = rot + QuarterTurn;
      z_start = $signed({1'b0, fold_angle[22:0]}) - $signed(QuarterTurn);
      chain[0].valid = (state_ff == ST_ROT);
      chain[0].x = CordicXInit;
      chain[0].y = '0;
      chain[0].z = {{2{z_start[23]}}, z_start, 8'd0};
      sum_x = 51'(pa_ff) - 51'(pb_ff) + 51'sd524288;
      sum_y = 51'(pc_ff) + 51'(pd_ff) + 51'sd524288;
      rq_x = 57'(qx_ff) + 57'sd8388608;
      rq_y = 57'(qy_ff) + 57'sd8388608;
      acc_x = 34'(pos_x_ff) + 34'($signed(rq_x[56:24]));
      acc_y = 34'(pos_y_ff) + 34'($signed(rq_y[56:24]));
      pos_x_in = sat32(acc_x);
      pos_y_in = sat32(acc_y);
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      poi_cordic_cell #(.IDX(i)) u_cell (
         .clock(clock),
         .reset(reset),
         .bus_in(chain[i]),
         .bus_ff(chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         method_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         angle_ff <= '0;
         last_stamp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            method_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_DT;
               end
            end
            ST_DT: state_ff <= ST_P;
            ST_P: state_ff <= ST_KMUL;
            ST_KMUL: state_ff <= ST_TURN;
            ST_TURN: state_ff <= ST_ROT;
            ST_ROT: state_ff <= ST_CORDIC;
            ST_CORDIC: begin
               if (chain[CORDIC_STEPS].valid) begin
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: state_ff <= ST_MUL2;
            ST_MUL2: state_ff <= ST_RX;
            ST_RX: state_ff <= ST_PX;
            ST_PX: state_ff <= ST_ACC;
            ST_ACC: begin
               pos_x_ff <= pos_x_in;
               pos_y_ff <= pos_y_in;
               angle_ff <= angle_ff + step_ff;
               last_stamp_ff <= stamp_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         stamp_ff <= req_tdata[39:0];
         vx_ff <= req_tdata[55:40];
         vy_ff <= req_tdata[71:56];
         w_ff <= req_tdata[87:72];
      end
      if (state_ff == ST_DT) begin
         dt_ff <= dt_in;
      end
      if (state_ff == ST_P) begin
         p_ff <= 41'(w_ff * $signed({1'b0, dt_ff}));
      end
      if (state_ff == ST_KMUL) begin
         klo_ff <= p_ff[23:0] * TurnConst;
         khi_ff <= 40'($signed(p_ff[40:24]) * $signed({1'b0, TurnConst}));
      end
      if (state_ff == ST_TURN) begin
         step_ff <= step_sum[55:32];
         half_ff <= half_sum[56:33];
      end
      if (state_ff == ST_ROT) begin
         folded_ff <= fold_angle[23];
      end
      if (state_ff == ST_CORDIC) begin
         c_ff <= folded_ff ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
         s_ff <= folded_ff ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
      end
      if (state_ff == ST_MUL1) begin
         pa_ff <= 50'(vx_ff * c_ff);
         pb_ff <= 50'(vy_ff * s_ff);
      end
      if (state_ff == ST_MUL2) begin
         pc_ff <= 50'(vx_ff * s_ff);
         pd_ff <= 50'(vy_ff * c_ff);
      end
      if (state_ff == ST_RX) begin
         rx_ff <= sum_x[50:20];
         ry_ff <= sum_y[50:20];
      end
      if (state_ff == ST_PX) begin
         qx_ff <= 56'(rx_ff * $signed({1'b0, dt_ff}));
         qy_ff <= 56'(ry_ff * $signed({1'b0, dt_ff}));
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {angle_ff, pos_y_ff, pos_x_ff};
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire
